// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ray and segment intersection block.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rsi_pkg.sv =====
// Package for the ray and segment intersection block: widths and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;
    localparam int COORD_W     = 32;
    localparam int FRAC_BITS_D = 16;
    localparam int CROSS_W     = 66;   // exact signed cross product
    localparam int MAG_W       = 65;   // magnitude of a cross product
    localparam int PROD_W      = 97;   // magnitude times direction magnitude
    localparam int QUO_W       = 97;
    localparam int DIV_BITS_D  = 4;    // quotient bits resolved per divider stage

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t ray_origin_x;
        coord_t ray_origin_y;
        coord_t ray_dir_x;
        coord_t ray_dir_y;
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
    } query_t;

    typedef struct packed {
        logic   hit;
        coord_t hit_x;
        coord_t hit_y;
    } answer_t;
endpackage
`default_nettype wire

// ===== rtl/rsi_if.sv =====
// Valid/ready channel interface carrying one payload of a given type.
// Depends on nothing but the payload type handed in.
`timescale 1ns / 1ps
`default_nettype none
interface rsi_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rsi_div_stage.sv =====
// One stage of the pipelined restoring divider: BITS quotient bits per stage.
// Uses rsi_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module rsi_div_stage #(
    parameter int BITS = 4,
    parameter int SHIFT = 0
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [rsi_pkg::QUO_W-1:0]  num_in,
    input  wire logic [rsi_pkg::MAG_W-1:0]  den_in,
    input  wire logic [rsi_pkg::MAG_W:0]    rem_in,
    input  wire logic [rsi_pkg::QUO_W-1:0]  quo_in,
    output logic      [rsi_pkg::QUO_W-1:0]  num_out,
    output logic      [rsi_pkg::MAG_W-1:0]  den_out,
    output logic      [rsi_pkg::MAG_W:0]    rem_out,
    output logic      [rsi_pkg::QUO_W-1:0]  quo_out
);
    import rsi_pkg::*;

    logic [MAG_W:0]   rem_next;
    logic [QUO_W-1:0] quo_next;
    logic [MAG_W+1:0] trial;

    // The remainder always stays below the divisor, so MAG_W+1 bits suffice.
    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        trial    = '0;
        for (int i = 0; i < BITS; i++)
        begin
            trial = {rem_next, num_in[QUO_W-1-SHIFT-i]};
            if (trial >= {1'b0, 1'b0, den_in})
            begin
                trial = trial - {2'b00, den_in};
                quo_next[QUO_W-1-SHIFT-i] = 1'b1;
            end
            rem_next = trial[MAG_W:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out <= num_in;
            den_out <= den_in;
            rem_out <= rem_next;
            quo_out <= quo_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rsi_coord_unit.sv =====
// One coordinate path: magnitude product, pipelined division, saturating add.
// Uses rsi_pkg and rsi_div_stage.
`timescale 1ns / 1ps
`default_nettype none
module rsi_coord_unit #(
    parameter int DIV_BITS = rsi_pkg::DIV_BITS_D
) (
    input  wire logic                      clk,
    input  wire logic [2+(rsi_pkg::QUO_W+DIV_BITS-1)/DIV_BITS:0] en,
    input  wire rsi_pkg::coord_t           org,
    input  wire rsi_pkg::coord_t           dir,
    input  wire logic [rsi_pkg::MAG_W-1:0] num_mag,
    input  wire logic [rsi_pkg::MAG_W-1:0] den_mag,
    output rsi_pkg::coord_t                coord
);
    import rsi_pkg::*;

    localparam int NSTG = (QUO_W + DIV_BITS - 1) / DIV_BITS;

    logic [COORD_W-1:0] dmag;
    logic [MAG_W-1:0]   num_reg, den_reg;
    logic [COORD_W-1:0] dmag_reg;
    logic               neg_reg;
    coord_t             org_reg;
    logic [QUO_W-1:0]   prod_lo_reg, prod_next;
    logic [MAG_W-1:0]   den1_reg;
    logic               neg1_reg;
    coord_t             org1_reg;

    logic [QUO_W-1:0] num_s [NSTG+1];
    logic [MAG_W-1:0] den_s [NSTG+1];
    logic [MAG_W:0]   rem_s [NSTG+1];
    logic [QUO_W-1:0] quo_s [NSTG+1];
    logic             neg_s [NSTG+1];
    coord_t           org_s [NSTG+1];

    logic signed [34:0] sum;
    coord_t             coord_next;

    assign dmag = dir[COORD_W-1] ? COORD_W'(-dir) : dir;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg  <= num_mag;
            den_reg  <= den_mag;
            dmag_reg <= dmag;
            neg_reg  <= dir[COORD_W-1];
            org_reg  <= org;
        end
    end

    // Split product: 65 x 32 formed as two narrower partial products.
    logic [63:0] p_lo;
    logic [64:0] p_hi;
    assign p_lo = {32'd0, num_reg[31:0]} * {32'd0, dmag_reg};
    assign p_hi = {32'd0, num_reg[MAG_W-1:32]} * {33'd0, dmag_reg};
    assign prod_next = {33'd0, p_lo} + {p_hi, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_lo_reg <= prod_next;
            den1_reg    <= den_reg;
            neg1_reg    <= neg_reg;
            org1_reg    <= org_reg;
        end
    end

    assign num_s[0] = prod_lo_reg;
    assign den_s[0] = den1_reg;
    assign rem_s[0] = '0;
    assign quo_s[0] = '0;
    assign neg_s[0] = neg1_reg;
    assign org_s[0] = org1_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_div
        localparam int NB = (QUO_W - g*DIV_BITS < DIV_BITS) ? QUO_W - g*DIV_BITS : DIV_BITS;
        rsi_div_stage #(.BITS(NB), .SHIFT(g*DIV_BITS)) u_stage (
            .clk(clk), .en(en[2+g]),
            .num_in(num_s[g]), .den_in(den_s[g]), .rem_in(rem_s[g]), .quo_in(quo_s[g]),
            .num_out(num_s[g+1]), .den_out(den_s[g+1]), .rem_out(rem_s[g+1]),
            .quo_out(quo_s[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en[2+g])
            begin
                neg_s[g+1] <= neg_s[g];
                org_s[g+1] <= org_s[g];
            end
        end
    end

    always_comb
    begin
        sum = neg_s[NSTG] ? 35'(org_s[NSTG]) - $signed({1'b0, quo_s[NSTG][33:0]})
                          : 35'(org_s[NSTG]) + $signed({1'b0, quo_s[NSTG][33:0]});
        if (quo_s[NSTG][QUO_W-1:33] != '0)
            coord_next = neg_s[NSTG] ? coord_t'(32'h8000_0000) : coord_t'(32'h7FFF_FFFF);
        else if (sum > 35'sh0_7FFF_FFFF)
            coord_next = coord_t'(32'h7FFF_FFFF);
        else if (sum < -35'sh0_8000_0000)
            coord_next = coord_t'(32'h8000_0000);
        else
            coord_next = sum[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2+NSTG])
            coord <= coord_next;
    end
endmodule
`default_nettype wire

// ===== rtl/rsi_cross_unit.sv =====
// Front end: differences, exact cross products and the hit decision.
// Uses rsi_pkg; three register stages.
`timescale 1ns / 1ps
`default_nettype none
module rsi_cross_unit (
    input  wire logic                      clk,
    input  wire logic [2:0]                en,
    input  wire rsi_pkg::query_t           q,
    output logic                           hit,
    output logic [rsi_pkg::MAG_W-1:0]      n1_mag,
    output logic [rsi_pkg::MAG_W-1:0]      den_mag,
    output rsi_pkg::query_t                q_out
);
    import rsi_pkg::*;

    logic signed [32:0] wx_reg, wy_reg, cx_reg, cy_reg;
    coord_t             dx_reg, dy_reg;
    query_t             q1_reg, q2_reg;
    logic signed [CROSS_W-1:0] a0_reg, a1_reg, b0_reg, b1_reg, c0_reg, c1_reg;
    logic signed [CROSS_W-1:0] den, n1, n2;
    logic [MAG_W-1:0]          dabs, n2abs;
    logic                      hit_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            wx_reg <= 33'(q.seg_start_x) - 33'(q.ray_origin_x);
            wy_reg <= 33'(q.seg_start_y) - 33'(q.ray_origin_y);
            cx_reg <= 33'(q.seg_end_x) - 33'(q.seg_start_x);
            cy_reg <= 33'(q.seg_end_y) - 33'(q.seg_start_y);
            dx_reg <= q.ray_dir_x;
            dy_reg <= q.ray_dir_y;
            q1_reg <= q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a0_reg <= CROSS_W'(dx_reg * cy_reg);
            a1_reg <= CROSS_W'(dy_reg * cx_reg);
            b0_reg <= CROSS_W'(wx_reg * cy_reg);
            b1_reg <= CROSS_W'(wy_reg * cx_reg);
            c0_reg <= CROSS_W'(wx_reg * dy_reg);
            c1_reg <= CROSS_W'(wy_reg * dx_reg);
            q2_reg <= q1_reg;
        end
    end

    always_comb
    begin
        den   = a0_reg - a1_reg;
        n1    = b0_reg - b1_reg;
        n2    = c0_reg - c1_reg;
        dabs  = den[CROSS_W-1] ? MAG_W'(-den) : MAG_W'(den);
        n2abs = n2[CROSS_W-1] ? MAG_W'(-n2) : MAG_W'(n2);
        hit_next = (den != '0);
        if (n1 != '0 && n1[CROSS_W-1] != den[CROSS_W-1])
            hit_next = 1'b0;
        if (n2 != '0 && n2[CROSS_W-1] != den[CROSS_W-1])
            hit_next = 1'b0;
        if (n2abs > dabs)
            hit_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hit     <= hit_next;
            n1_mag  <= n1[CROSS_W-1] ? MAG_W'(-n1) : MAG_W'(n1);
            // A zero divisor on a miss is harmless: the result is masked.
            den_mag <= (dabs == '0) ? MAG_W'(1) : dabs;
            q_out   <= q2_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ray_segment_intersection_top.sv =====
// Ray and segment intersection, fully pipelined.
// Accepts one request a cycle while the output is not stalled.
// The depth is set mostly by the pipelined 97-bit restoring divider per coordinate.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module ray_segment_intersection_top #(
    parameter int DIV_BITS = rsi_pkg::DIV_BITS_D
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rsi_if.sink       in_ch,
    rsi_if.source     out_ch
);
    import rsi_pkg::*;
    `include "assert_macros.svh"

    localparam int NSTG  = (QUO_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DEPTH = 3 + 3 + NSTG;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic             hit_c, hit_reg;
    logic [MAG_W-1:0] n1_mag, den_mag;
    query_t           qc;
    coord_t           hx, hy;
    logic [2+NSTG:0]  cen;
    logic [3+NSTG-1:0] hit_d_reg;

    assign adv          = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready  = adv;
    assign cen          = {(3+NSTG){adv}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    rsi_cross_unit u_cross (
        .clk(clk), .en({3{adv}}), .q(in_ch.data),
        .hit(hit_c), .n1_mag(n1_mag), .den_mag(den_mag), .q_out(qc)
    );

    rsi_coord_unit #(.DIV_BITS(DIV_BITS)) u_x (
        .clk(clk), .en(cen), .org(qc.ray_origin_x), .dir(qc.ray_dir_x),
        .num_mag(n1_mag), .den_mag(den_mag), .coord(hx)
    );

    rsi_coord_unit #(.DIV_BITS(DIV_BITS)) u_y (
        .clk(clk), .en(cen), .org(qc.ray_origin_y), .dir(qc.ray_dir_y),
        .num_mag(n1_mag), .den_mag(den_mag), .coord(hy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
            hit_d_reg <= {hit_d_reg[3+NSTG-2:0], hit_c};
    end
    assign hit_reg = hit_d_reg[3+NSTG-1];

    assign out_ch.valid      = vld_reg[DEPTH-1];
    assign out_ch.data.hit   = hit_reg;
    assign out_ch.data.hit_x = hit_reg ? hx : '0;
    assign out_ch.data.hit_y = hit_reg ? hy : '0;

    `ASSERT_IMPL(a_stall_hold_ready, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
    `ASSERT_NEXT(a_stall_keeps_valid, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.data.hit, out_ch.data.hit_x == '0 && out_ch.data.hit_y == '0)
endmodule
`default_nettype wire
